FILE: rtl/core/salc_pkg.sv
// Shared types and codes for the size-aware LRU cache table.
// No dependencies; every other file imports this package.
package salc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam logic [31:0] CAP_RESET = 32'd65536;

	localparam logic [2:0] OP_GET   = 3'd0;
	localparam logic [2:0] OP_INS   = 3'd1;
	localparam logic [2:0] OP_ERASE = 3'd2;
	localparam logic [2:0] OP_FORCE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [63:0] key;
		logic [31:0] size;
	} salc_req_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic [1:0]  status;
		logic [31:0] freed_bytes;
		logic [4:0]  evicted_count;
		logic [31:0] used_bytes;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} salc_rsp_t;

	// Classified command between the front and back parts.
	typedef struct packed {
		logic        is_get;
		logic        is_ins;
		logic        is_erase;
		logic        is_force;
		logic        is_clear;
		logic [63:0] key;
		logic [31:0] size;
	} salc_cmd_t;

endpackage

FILE: rtl/core/salc_front.sv
// Front part: accepts request transactions, decodes the operation and
// queues the command for the back part. Depends on salc_pkg.
module salc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  salc_pkg::salc_req_t req,
	output logic                cmd_valid,
	input  logic                cmd_pop,
	output salc_pkg::salc_cmd_t cmd
);
	import salc_pkg::*;

	salc_cmd_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	salc_cmd_t  dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec = '0;
		dec.key = req.key;
		dec.size = req.size;
		case (req.operation)
			OP_GET:   dec.is_get = 1'b1;
			OP_INS:   dec.is_ins = 1'b1;
			OP_ERASE: dec.is_erase = 1'b1;
			OP_FORCE: dec.is_force = 1'b1;
			OP_CLEAR: dec.is_clear = 1'b1;
			default:  dec.is_get = 1'b0;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop = cmd_pop && cmd_valid;
	assign cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

endmodule

FILE: rtl/core/salc_back.sv
// Back part: the table itself, the eviction sequencer and the result register.
// Depends on salc_pkg.
module salc_back #(
	parameter int ENTRIES = salc_pkg::ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         capacity,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  salc_pkg::salc_cmd_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output salc_pkg::salc_rsp_t rsp
);
	import salc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EVICT = 3'd2;
	localparam logic [2:0] S_INS   = 3'd3;
	localparam logic [2:0] S_FORCE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]    state_q;
	logic [63:0]   key_q   [ENTRIES];
	logic [31:0]   size_q  [ENTRIES];
	logic [IW-1:0] rank_q  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;
	logic [31:0]   occ_q;
	logic [31:0]   hits_q;
	logic [31:0]   miss_q;

	salc_cmd_t     cmd_q;
	logic          hit_q;
	logic [IW-1:0] slot_q;
	logic [1:0]    status_q;
	logic [31:0]   freed_q;
	logic [CW-1:0] evc_q;
	logic          rsp_valid_q;
	salc_rsp_t     rsp_q;

	logic          match_any;
	logic [IW-1:0] match_idx;
	logic [IW-1:0] old_idx;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] last_rank;
	logic          need_room;
	logic          do_evict;
	logic          do_force;
	logic          load_rsp;
	logic [IW+3:0] slot_ext;
	logic [CW+4:0] evc_ext;

	assign last_rank = IW'(count_q - CW'(1));
	assign slot_ext = {4'b0, slot_q};
	assign evc_ext = {5'b0, evc_q};

	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		old_idx = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == cmd_q.key) begin
				match_any = 1'b1;
				match_idx = IW'(i);
			end
			if (valid_q[i] && rank_q[i] == last_rank) old_idx = IW'(i);
			if (!valid_q[i]) free_idx = IW'(i);
		end
	end

	assign need_room = ({1'b0, occ_q} + {1'b0, cmd_q.size} > {1'b0, capacity})
		|| (count_q == CW'(ENTRIES));
	assign do_evict = (state_q == S_EVICT) && need_room;
	assign do_force = (state_q == S_FORCE) && (freed_q < cmd_q.size)
		&& (count_q != '0);
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	// Key and size are written only on insert.
	always_ff @(posedge clk) begin
		if (state_q == S_INS) begin
			key_q[free_idx] <= cmd_q.key;
			size_q[free_idx] <= cmd_q.size;
		end
	end

	// Recency ranks: 0 is most recent.
	always_ff @(posedge clk) begin
		if (state_q == S_LOOK && match_any && cmd_q.is_get) begin
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i] && rank_q[i] < rank_q[match_idx])
					rank_q[i] <= rank_q[i] + IW'(1);
			rank_q[match_idx] <= '0;
		end else if (state_q == S_LOOK && match_any && cmd_q.is_erase) begin
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i] && rank_q[i] > rank_q[match_idx])
					rank_q[i] <= rank_q[i] - IW'(1);
		end else if (state_q == S_INS) begin
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i]) rank_q[i] <= rank_q[i] + IW'(1);
			rank_q[free_idx] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
		if (load_rsp) begin
			rsp_q.hit <= hit_q;
			rsp_q.slot <= slot_ext[3:0];
			rsp_q.status <= status_q;
			rsp_q.freed_bytes <= freed_q;
			rsp_q.evicted_count <= evc_ext[4:0];
			rsp_q.used_bytes <= occ_q;
			rsp_q.hit_total <= hits_q;
			rsp_q.miss_total <= miss_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			occ_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			hit_q <= 1'b0;
			slot_q <= '0;
			status_q <= ST_OK;
			freed_q <= '0;
			evc_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						hit_q <= 1'b0;
						slot_q <= '0;
						status_q <= ST_OK;
						freed_q <= '0;
						evc_q <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_DONE;
					if (cmd_q.is_get || cmd_q.is_ins) begin
						if (match_any) begin
							hit_q <= 1'b1;
							slot_q <= match_idx;
							if (cmd_q.is_get && hits_q != '1) hits_q <= hits_q + 32'd1;
						end else begin
							if (cmd_q.is_get && miss_q != '1) miss_q <= miss_q + 32'd1;
							if (cmd_q.size > capacity) status_q <= ST_TOO_BIG;
							else state_q <= S_EVICT;
						end
					end else if (cmd_q.is_erase) begin
						if (match_any) begin
							hit_q <= 1'b1;
							freed_q <= size_q[match_idx];
							evc_q <= CW'(1);
							valid_q[match_idx] <= 1'b0;
							count_q <= count_q - CW'(1);
							occ_q <= occ_q - size_q[match_idx];
						end
					end else if (cmd_q.is_force) begin
						if (occ_q < cmd_q.size) status_q <= ST_REFUSED;
						else state_q <= S_FORCE;
					end else if (cmd_q.is_clear) begin
						freed_q <= occ_q;
						evc_q <= count_q;
						valid_q <= '0;
						count_q <= '0;
						occ_q <= '0;
					end
				end
				S_EVICT, S_FORCE: begin
					if (do_evict || do_force) begin
						// The oldest entry holds the highest rank: no rank shifts.
						valid_q[old_idx] <= 1'b0;
						count_q <= count_q - CW'(1);
						occ_q <= occ_q - size_q[old_idx];
						freed_q <= freed_q + size_q[old_idx];
						evc_q <= evc_q + CW'(1);
					end else begin
						state_q <= (state_q == S_EVICT) ? S_INS : S_DONE;
					end
				end
				S_INS: begin
					valid_q[free_idx] <= 1'b1;
					count_q <= count_q + CW'(1);
					occ_q <= occ_q + cmd_q.size;
					slot_q <= free_idx;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_rsp) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: rtl/core/size_aware_lru_cache_table_unit.sv
// Top level of the size-aware LRU cache table: front queue, back engine and
// the capacity register. Depends on salc_pkg, salc_front and salc_back.
//
// A fully associative table of ENTRIES keys with byte sizes, kept in recency
// order under the byte budget in capacity (written through cfg_we/cfg_wdata,
// reset 65536). Each request transaction (get, insert, erase, force evict,
// clear) yields exactly one response transaction. The front part takes
// requests into a two-deep command queue; the back part executes one command
// at a time. A command goes from queue to response register by dequeue,
// parallel key match and act, and load result. A get or insert miss that fits
// also passes through the evictions, a final fit check and an insert step; a
// force evict that is not refused passes through the evictions and a final
// check. The eviction sequencer removes one least recent entry per cycle. The
// response register lets the next command proceed while a finished response
// is still stalled. Write capacity only while idle.
module size_aware_lru_cache_table_unit #(
	parameter int ENTRIES = salc_pkg::ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  salc_pkg::salc_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output salc_pkg::salc_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import salc_pkg::*;

	logic        cap_we_ok;
	logic [31:0] capacity_q;
	logic        cmd_valid;
	logic        cmd_pop;
	salc_cmd_t   cmd;

	assign cap_we_ok = cfg_we;

	// Hold the byte budget; load it on every configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cap_we_ok) begin
			capacity_q <= cfg_wdata;
		end
	end

	salc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	salc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A hit never comes with an error status.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.status == ST_OK)
		else $error("hit with error status");

	// A refused force evict removes nothing.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_REFUSED |->
		rsp.freed_bytes == 32'd0 && rsp.evicted_count == 5'd0)
		else $error("refused force evict freed bytes");

	// An oversized object is neither placed nor causes evictions.
	a_too_big: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_TOO_BIG |->
		rsp.slot == 4'd0 && rsp.freed_bytes == 32'd0)
		else $error("oversized object changed the table");

endmodule
